/* src/rsp_pkg.sv */
`timescale 1ns / 1ps

package rsp_pkg;

    localparam int SCREEN_WIDTH = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int HALF_H = SCREEN_HEIGHT / 2;

    // road half width in world units, and its scale against Q4.12 depth
    localparam int ROAD_HALF_SPAN = 80;
    localparam int HW_SCALE = (ROAD_HALF_SPAN / 16) * SCREEN_WIDTH;

    // power-of-two factors of the projection denominators
    localparam int X_SHIFT = 19;
    localparam int Y_SHIFT = 13;
    localparam int HW_SHIFT = 1;
    localparam int CURVE_SHIFT = 6;

    localparam int FIELD_W = 16;
    localparam int ACC_W = 32;
    localparam int DZ_W = ACC_W + 1;
    localparam int CX_W = 40;
    localparam int CXM_W = CX_W - 1;
    localparam int SW_BITS = $clog2(SCREEN_WIDTH + 1);
    localparam int CXW_W = CXM_W + SW_BITS;
    localparam int NUM_W = FIELD_W + CXW_W;

    // quotient bits: y and half width stay exact, x only needs to saturate
    localparam int QW_X_MIN = 17;
    localparam int QW_Y = $clog2(SCREEN_HEIGHT * 128 + 1);
    localparam int QW_HW = $clog2(SCREEN_WIDTH * 40 + 1);
    localparam int QW_A = (QW_Y > QW_HW) ? QW_Y : QW_HW;
    localparam int QW_PROJ = (QW_A > QW_X_MIN) ? QW_A : QW_X_MIN;
    localparam int QW_SLOPE = 32;
    localparam int QUO_W = QW_SLOPE;
    localparam int QCNT_W = $clog2(QW_SLOPE + 1);
    localparam int SCR_W = QUO_W + 2;

    localparam int DEN_W = DZ_W + X_SHIFT;
    localparam int DSH_A = DEN_W + QW_PROJ - 1;
    localparam int DSH_B = FIELD_W + QW_SLOPE - 1;
    localparam int DSH_W = (DSH_A > DSH_B) ? DSH_A : DSH_B;
    localparam int CMP_W = (NUM_W > DSH_W + 1) ? NUM_W : DSH_W + 1;

    // n/3 as a multiply by reciprocal, exact for 16-bit n
    localparam int RECIP3 = 43691;
    localparam int RECIP3_SHIFT = 17;
    localparam int RECIP_W = 32;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_HEIGHT = 1'd1;
    localparam logic [FIELD_W-1:0] VIEW_DEPTH_RESET = 16'd4096;
    localparam logic [FIELD_W-1:0] EYE_HEIGHT_RESET = 16'd256;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NEAR_X = 3'd0;
    localparam logic [OP_W-1:0] OP_NEAR_Y = 3'd1;
    localparam logic [OP_W-1:0] OP_NEAR_HW = 3'd2;
    localparam logic [OP_W-1:0] OP_FAR_X = 3'd3;
    localparam logic [OP_W-1:0] OP_FAR_Y = 3'd4;
    localparam logic [OP_W-1:0] OP_FAR_HW = 3'd5;
    localparam logic [OP_W-1:0] OP_SLOPE = 3'd6;
    localparam logic [OP_W-1:0] OP_LAST = OP_FAR_HW;

    typedef struct packed {
        logic load_item;
        logic frame_init;
        logic prep;
        logic div_start;
        logic result_store;
        logic out_load;
        logic [OP_W-1:0] op;
    } rsp_cmd_t;

    typedef struct packed {
        logic frame_start;
        logic len_nonzero;
        logic projected;
        logic div_done;
    } rsp_status_t;

endpackage

/* src/rsp_seg_if.sv */
`timescale 1ns / 1ps

interface rsp_seg_if import rsp_pkg::*; ();
    logic valid;
    logic ready;
    logic frame_start;
    logic signed [FIELD_W-1:0] seg_curve;
    logic [FIELD_W-1:0] seg_length;
    logic [FIELD_W-1:0] seg_number;
    logic [FIELD_W-1:0] cam_offset;
    logic signed [FIELD_W-1:0] player_lateral;

    modport source (
        output valid, frame_start, seg_curve, seg_length, seg_number, cam_offset,
        player_lateral,
        input ready
    );

    modport sink (
        input valid, frame_start, seg_curve, seg_length, seg_number, cam_offset,
        player_lateral,
        output ready
    );
endinterface

/* src/rsp_res_if.sv */
`timescale 1ns / 1ps

interface rsp_res_if import rsp_pkg::*; ();
    logic valid;
    logic ready;
    logic visible;
    logic signed [FIELD_W-1:0] near_x;
    logic signed [FIELD_W-1:0] near_y;
    logic [FIELD_W-1:0] near_half_width;
    logic signed [FIELD_W-1:0] far_x;
    logic signed [FIELD_W-1:0] far_y;
    logic [FIELD_W-1:0] far_half_width;
    logic stripe_light;
    logic lane_mark;

    modport source (
        output valid, visible, near_x, near_y, near_half_width, far_x, far_y,
        far_half_width, stripe_light, lane_mark,
        input ready
    );

    modport sink (
        input valid, visible, near_x, near_y, near_half_width, far_x, far_y,
        far_half_width, stripe_light, lane_mark,
        output ready
    );
endinterface

/* src/rsp_div.sv */
`timescale 1ns / 1ps

module rsp_div import rsp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DSH_W-1:0]  dsh,
    input  logic [QCNT_W-1:0] qbits,
    output logic              done,
    output logic [QUO_W-1:0]  quot
);

    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  q_reg;
    logic              ovf_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;
    logic [NUM_W-1:0]  diff;

    // restoring division, one quotient bit per cycle
    assign ge = CMP_W'(rem_reg) >= CMP_W'(dsh_reg);
    assign diff = rem_reg - NUM_W'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= qbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= dsh;
            q_reg <= '0;
            ovf_reg <= CMP_W'(num) >= (CMP_W'(dsh) << 1);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= diff;
            end
            q_reg <= {q_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = ovf_reg ? '1 : q_reg;

endmodule

/* src/rsp_ctrl.sv */
`timescale 1ns / 1ps

module rsp_ctrl import rsp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  rsp_status_t status,
    output rsp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENTRY = 3'd1;
    localparam logic [2:0] S_SLOPE_WAIT = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DIV_GO = 3'd5;
    localparam logic [2:0] S_DIV_WAIT = 3'd6;
    localparam logic [2:0] S_OUT = 3'd7;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [OP_W-1:0] op_reg;
    logic [OP_W-1:0] op_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        cmd.op = op_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                state_next = S_PREP;
                if (status.frame_start)
                begin
                    cmd.frame_init = 1'b1;
                    if (status.len_nonzero)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.op = OP_SLOPE;
                        state_next = S_SLOPE_WAIT;
                    end
                end
            end
            S_SLOPE_WAIT:
            begin
                cmd.op = OP_SLOPE;
                if (status.div_done)
                begin
                    cmd.result_store = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                op_next = OP_NEAR_X;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.projected ? S_DIV_GO : S_OUT;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.result_store = 1'b1;
                    if (op_reg == OP_LAST)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        op_next = op_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_NEAR_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* src/rsp_dp.sv */
`timescale 1ns / 1ps

module rsp_dp import rsp_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [FIELD_W-1:0]        cfg_data,
    input  rsp_cmd_t                  cmd,
    output rsp_status_t               status,
    input  logic                      frame_start,
    input  logic signed [FIELD_W-1:0] seg_curve,
    input  logic [FIELD_W-1:0]        seg_length,
    input  logic [FIELD_W-1:0]        seg_number,
    input  logic [FIELD_W-1:0]        cam_offset,
    input  logic signed [FIELD_W-1:0] player_lateral,
    output logic                      visible,
    output logic signed [FIELD_W-1:0] near_x,
    output logic signed [FIELD_W-1:0] near_y,
    output logic [FIELD_W-1:0]        near_half_width,
    output logic signed [FIELD_W-1:0] far_x,
    output logic signed [FIELD_W-1:0] far_y,
    output logic [FIELD_W-1:0]        far_half_width,
    output logic                      stripe_light,
    output logic                      lane_mark
);

    function automatic logic signed [FIELD_W-1:0] sat16(input logic signed [SCR_W-1:0] v);
        logic hi_same;
        hi_same = (&v[SCR_W-1:FIELD_W-1]) || !(|v[SCR_W-1:FIELD_W-1]);
        if (hi_same)
            return v[FIELD_W-1:0];
        else if (v[SCR_W-1])
            return {1'b1, {(FIELD_W-1){1'b0}}};
        else
            return {1'b0, {(FIELD_W-1){1'b1}}};
    endfunction

    function automatic logic signed [ACC_W-1:0] sat32(input logic signed [ACC_W:0] v);
        if (v[ACC_W] == v[ACC_W-1])
            return v[ACC_W-1:0];
        else if (v[ACC_W])
            return {1'b1, {(ACC_W-1){1'b0}}};
        else
            return {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    logic [FIELD_W-1:0]        view_depth_reg;
    logic [FIELD_W-1:0]        eye_height_reg;

    logic                      frame_start_reg;
    logic signed [FIELD_W-1:0] curve_reg;
    logic [FIELD_W-1:0]        length_reg;
    logic [FIELD_W-1:0]        number_reg;
    logic [FIELD_W-1:0]        offset_reg;
    logic signed [FIELD_W-1:0] lateral_in_reg;

    logic signed [ACC_W-1:0]   curve_offset_reg;
    logic signed [ACC_W-1:0]   curve_slope_reg;
    logic signed [ACC_W-1:0]   run_distance_reg;
    logic signed [FIELD_W-1:0] lateral_hold_reg;

    logic [DZ_W-1:0]           dz1_reg;
    logic [DZ_W-1:0]           dz2_reg;
    logic [CXW_W-1:0]          cxw1_reg;
    logic [CXW_W-1:0]          cxw2_reg;
    logic                      cx1_neg_reg;
    logic                      cx2_neg_reg;
    logic [ACC_W-1:0]          dh_reg;
    logic                      proj_reg;

    logic signed [FIELD_W-1:0] near_x_reg;
    logic signed [FIELD_W-1:0] far_x_reg;
    logic [QUO_W-1:0]          near_yq_reg;
    logic [QUO_W-1:0]          far_yq_reg;
    logic [FIELD_W-1:0]        near_hw_reg;
    logic [FIELD_W-1:0]        far_hw_reg;

    logic                      visible_reg;
    logic signed [FIELD_W-1:0] near_x_out_reg;
    logic signed [FIELD_W-1:0] near_y_out_reg;
    logic [FIELD_W-1:0]        near_hw_out_reg;
    logic signed [FIELD_W-1:0] far_x_out_reg;
    logic signed [FIELD_W-1:0] far_y_out_reg;
    logic [FIELD_W-1:0]        far_hw_out_reg;
    logic                      stripe_reg;
    logic                      lane_reg;

    logic signed [ACC_W:0]     offset_sum;
    logic signed [ACC_W:0]     slope_sum;
    logic signed [ACC_W:0]     run_sum;
    logic signed [DZ_W-1:0]    dz1_s;
    logic signed [DZ_W-1:0]    dz2_s;
    logic signed [CX_W-1:0]    lat80;
    logic signed [CX_W-1:0]    x_ext;
    logic signed [CX_W-1:0]    xsum_ext;
    logic signed [CX_W-1:0]    cx1;
    logic signed [CX_W-1:0]    cx2;
    logic [CXM_W-1:0]          cx1_mag;
    logic [CXM_W-1:0]          cx2_mag;
    logic                      proj_c;

    logic [FIELD_W-1:0]        curve_mag;
    logic [NUM_W-1:0]          div_num;
    logic [DSH_W-1:0]          div_dsh;
    logic [QCNT_W-1:0]         div_qbits;
    logic                      div_done;
    logic [QUO_W-1:0]          div_quot;

    logic signed [SCR_W-1:0]   q_s;
    logic signed [SCR_W-1:0]   xq;
    logic signed [SCR_W-1:0]   sx;
    logic [FIELD_W-1:0]        hw_sat;
    logic signed [ACC_W-1:0]   slope_q;
    logic signed [SCR_W-1:0]   ny_full;
    logic signed [SCR_W-1:0]   fy_full;
    logic [RECIP_W-1:0]        third;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_depth_reg <= VIEW_DEPTH_RESET;
            eye_height_reg <= EYE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VIEW_DEPTH: view_depth_reg <= cfg_data;
                REG_EYE_HEIGHT: eye_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // accumulator updates and edge terms
    assign offset_sum = {curve_offset_reg[ACC_W-1], curve_offset_reg}
                      + {curve_slope_reg[ACC_W-1], curve_slope_reg};
    assign slope_sum = {curve_slope_reg[ACC_W-1], curve_slope_reg} + (ACC_W + 1)'(curve_reg);
    assign run_sum = {run_distance_reg[ACC_W-1], run_distance_reg}
                   + $signed({{(ACC_W + 1 - FIELD_W){1'b0}}, length_reg});

    assign dz1_s = DZ_W'(run_distance_reg);
    assign dz2_s = dz1_s + $signed({{(DZ_W - FIELD_W){1'b0}}, length_reg});

    assign lat80 = CX_W'(lateral_hold_reg) * CX_W'(ROAD_HALF_SPAN);
    assign x_ext = CX_W'(curve_offset_reg);
    assign xsum_ext = x_ext + CX_W'(curve_slope_reg);
    assign cx1 = lat80 - (x_ext <<< CURVE_SHIFT);
    assign cx2 = lat80 - (xsum_ext <<< CURVE_SHIFT);
    assign cx1_mag = cx1[CX_W-1] ? CXM_W'(-cx1) : CXM_W'(cx1);
    assign cx2_mag = cx2[CX_W-1] ? CXM_W'(-cx2) : CXM_W'(cx2);

    assign proj_c = !run_distance_reg[ACC_W-1] && (run_distance_reg != '0)
                  && ({run_distance_reg[ACC_W-2:0], 4'b0000} > (ACC_W + 3)'(view_depth_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_offset_reg <= '0;
            curve_slope_reg <= '0;
            run_distance_reg <= '0;
            lateral_hold_reg <= '0;
        end
        else if (cmd.frame_init)
        begin
            curve_offset_reg <= '0;
            curve_slope_reg <= '0;
            run_distance_reg <= $signed(ACC_W'(0) - ACC_W'(offset_reg));
            lateral_hold_reg <= lateral_in_reg;
        end
        else if (cmd.prep)
        begin
            curve_offset_reg <= sat32(offset_sum);
            curve_slope_reg <= sat32(slope_sum);
            run_distance_reg <= sat32(run_sum);
        end
        else if (cmd.result_store && (cmd.op == OP_SLOPE))
        begin
            curve_slope_reg <= slope_q;
        end
    end

    // divider operands
    assign curve_mag = curve_reg[FIELD_W-1] ? FIELD_W'(-curve_reg) : FIELD_W'(curve_reg);

    always_comb
    begin
        div_num = '0;
        div_dsh = '0;
        div_qbits = QCNT_W'(QW_PROJ);
        case (cmd.op)
            OP_NEAR_X:
            begin
                div_num = NUM_W'(view_depth_reg) * NUM_W'(cxw1_reg);
                div_dsh = DSH_W'(dz1_reg) << (X_SHIFT + QW_PROJ - 1);
            end
            OP_FAR_X:
            begin
                div_num = NUM_W'(view_depth_reg) * NUM_W'(cxw2_reg);
                div_dsh = DSH_W'(dz2_reg) << (X_SHIFT + QW_PROJ - 1);
            end
            OP_NEAR_Y:
            begin
                div_num = NUM_W'(dh_reg) * NUM_W'(SCREEN_HEIGHT);
                div_dsh = DSH_W'(dz1_reg) << (Y_SHIFT + QW_PROJ - 1);
            end
            OP_FAR_Y:
            begin
                div_num = NUM_W'(dh_reg) * NUM_W'(SCREEN_HEIGHT);
                div_dsh = DSH_W'(dz2_reg) << (Y_SHIFT + QW_PROJ - 1);
            end
            OP_NEAR_HW:
            begin
                div_num = NUM_W'(view_depth_reg) * NUM_W'(HW_SCALE);
                div_dsh = DSH_W'(dz1_reg) << (HW_SHIFT + QW_PROJ - 1);
            end
            OP_FAR_HW:
            begin
                div_num = NUM_W'(view_depth_reg) * NUM_W'(HW_SCALE);
                div_dsh = DSH_W'(dz2_reg) << (HW_SHIFT + QW_PROJ - 1);
            end
            OP_SLOPE:
            begin
                div_num = NUM_W'(curve_mag) * NUM_W'(offset_reg);
                div_dsh = DSH_W'(length_reg) << (QW_SLOPE - 1);
                div_qbits = QCNT_W'(QW_SLOPE);
            end
            default: ;
        endcase
    end

    rsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .dsh   (div_dsh),
        .qbits (div_qbits),
        .done  (div_done),
        .quot  (div_quot)
    );

    // quotient post-processing
    assign q_s = $signed({2'b00, div_quot});
    assign xq = ((cmd.op == OP_NEAR_X) ? cx1_neg_reg : cx2_neg_reg) ? -q_s : q_s;
    assign sx = SCR_W'(HALF_W) - xq;
    assign hw_sat = (|div_quot[QUO_W-1:FIELD_W]) ? '1 : div_quot[FIELD_W-1:0];
    assign slope_q = curve_reg[FIELD_W-1] ? $signed(div_quot) : $signed(ACC_W'(0) - div_quot);

    assign ny_full = SCR_W'(HALF_H) + $signed({2'b00, near_yq_reg});
    assign fy_full = SCR_W'(HALF_H) + $signed({2'b00, far_yq_reg});
    assign third = (RECIP_W'(number_reg) * RECIP_W'(RECIP3)) >> RECIP3_SHIFT;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            frame_start_reg <= frame_start;
            curve_reg <= seg_curve;
            length_reg <= seg_length;
            number_reg <= seg_number;
            offset_reg <= cam_offset;
            lateral_in_reg <= player_lateral;
        end
        if (cmd.prep)
        begin
            dz1_reg <= dz1_s;
            dz2_reg <= dz2_s;
            cxw1_reg <= CXW_W'(cx1_mag) * CXW_W'(SCREEN_WIDTH);
            cxw2_reg <= CXW_W'(cx2_mag) * CXW_W'(SCREEN_WIDTH);
            cx1_neg_reg <= cx1[CX_W-1];
            cx2_neg_reg <= cx2[CX_W-1];
            dh_reg <= ACC_W'(view_depth_reg) * ACC_W'(eye_height_reg);
            proj_reg <= proj_c;
        end
        if (cmd.result_store)
        begin
            case (cmd.op)
                OP_NEAR_X: near_x_reg <= sat16(sx);
                OP_FAR_X: far_x_reg <= sat16(sx);
                OP_NEAR_Y: near_yq_reg <= div_quot;
                OP_FAR_Y: far_yq_reg <= div_quot;
                OP_NEAR_HW: near_hw_reg <= hw_sat;
                OP_FAR_HW: far_hw_reg <= hw_sat;
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            visible_reg <= proj_reg && (far_yq_reg < near_yq_reg);
            near_x_out_reg <= proj_reg ? near_x_reg : '0;
            near_y_out_reg <= proj_reg ? sat16(ny_full) : '0;
            near_hw_out_reg <= proj_reg ? near_hw_reg : '0;
            far_x_out_reg <= proj_reg ? far_x_reg : '0;
            far_y_out_reg <= proj_reg ? sat16(fy_full) : '0;
            far_hw_out_reg <= proj_reg ? far_hw_reg : '0;
            stripe_reg <= !third[0];
            lane_reg <= !number_reg[1];
        end
    end

    assign status.frame_start = frame_start_reg;
    assign status.len_nonzero = |length_reg;
    assign status.projected = proj_reg;
    assign status.div_done = div_done;

    assign visible = visible_reg;
    assign near_x = near_x_out_reg;
    assign near_y = near_y_out_reg;
    assign near_half_width = near_hw_out_reg;
    assign far_x = far_x_out_reg;
    assign far_y = far_y_out_reg;
    assign far_half_width = far_hw_out_reg;
    assign stripe_light = stripe_reg;
    assign lane_mark = lane_reg;

endmodule

/* src/road_segment_projector_core.sv */
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// seg_in    in         valid / ready        one road segment
// res_out   out        valid / ready        projected near and far edges
// cfg       in         cfg_write, no ready  view depth, eye height
//
// one item at a time; a projected item runs six divisions of 17 quotient bits
// in turn on the shared bit-serial divider
// a frame's first item with nonzero length also runs the 32-bit slope division
// an item too close to project skips the divisions
// the result register frees seg_in while a result waits on res_out
// reset restores view depth 4096, eye height 256, accumulators zero

module road_segment_projector_core import rsp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    rsp_seg_if.sink              seg_in,
    rsp_res_if.source            res_out
);

    rsp_cmd_t    cmd;
    rsp_status_t status;
    logic        in_ready;
    logic        out_valid;

    rsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_in.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (res_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status),
        .frame_start     (seg_in.frame_start),
        .seg_curve       (seg_in.seg_curve),
        .seg_length      (seg_in.seg_length),
        .seg_number      (seg_in.seg_number),
        .cam_offset      (seg_in.cam_offset),
        .player_lateral  (seg_in.player_lateral),
        .visible         (res_out.visible),
        .near_x          (res_out.near_x),
        .near_y          (res_out.near_y),
        .near_half_width (res_out.near_half_width),
        .far_x           (res_out.far_x),
        .far_y           (res_out.far_y),
        .far_half_width  (res_out.far_half_width),
        .stripe_light    (res_out.stripe_light),
        .lane_mark       (res_out.lane_mark)
    );

    assign seg_in.ready = in_ready;
    assign res_out.valid = out_valid;

endmodule

/* src/rsp_checker.sv */
`timescale 1ns / 1ps

module rsp_checker import rsp_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      visible,
    input logic signed [FIELD_W-1:0] near_y,
    input logic signed [FIELD_W-1:0] far_y,
    input logic [FIELD_W-1:0]        near_half_width,
    input logic [FIELD_W-1:0]        far_half_width
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item taken while one is in work");

    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> far_y <= near_y)
        else $error("visible segment with far edge below near edge");

    a_width_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> far_half_width <= near_half_width)
        else $error("far half width exceeds near half width");

endmodule

bind road_segment_projector_core rsp_checker u_rsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (seg_in.valid),
    .in_ready        (seg_in.ready),
    .out_valid       (res_out.valid),
    .out_ready       (res_out.ready),
    .visible         (res_out.visible),
    .near_y          (res_out.near_y),
    .far_y           (res_out.far_y),
    .near_half_width (res_out.near_half_width),
    .far_half_width  (res_out.far_half_width)
);
